// ===== hdl/vcse_pkg.sv =====
// ----------------------------------------------------------------------------
// vcse_pkg
// Shared types and constants of the voxel column span encoder: request and
// write payloads, the command word between front and back, write slot codes.
// ----------------------------------------------------------------------------
`default_nettype none

package vcse_pkg;

	// byte offset arithmetic width
	localparam int OFFSET_BITS = 24;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// configuration port
	localparam int PADDR_BITS = 2;
	localparam logic [PADDR_BITS-1:0] ADDR_COLUMN_HEIGHT = PADDR_BITS'(0);
	localparam logic [7:0] COLUMN_HEIGHT_RESET = 8'd255;

	typedef logic [OFFSET_BITS-1:0] offset_t;

	// write slots, in the order the back part emits them
	typedef enum logic [3:0] {
		SLOT_CLOSE,
		SLOT_SKIP,
		SLOT_ONE,
		SLOT_COL,
		SLOT_NRM,
		SLOT_PATCH,
		SLOT_TRAIL,
		SLOT_REM,
		SLOT_ZERO,
		SLOT_ERR
	} slot_t;

	localparam int NUM_SLOTS = 10;

	typedef logic [NUM_SLOTS-1:0] slot_mask_t;

	// input request
	typedef struct packed {
		logic [7:0] voxel_z;
		logic [7:0] color_index;
		logic [7:0] normal_index;
		logic       column_last;
		logic       section_first;
	} voxel_t;

	// output byte write
	typedef struct packed {
		logic [23:0] write_offset;
		logic [7:0]  write_byte;
		logic [23:0] column_start;
		logic        column_done;
		logic        encode_error;
		logic        last_write;
	} write_t;

	// classified request handed from front to back
	typedef struct packed {
		slot_mask_t mask;
		offset_t    base;
		offset_t    patch_off;
		offset_t    col_start;
		logic [7:0] color;
		logic [7:0] normal;
		logic [7:0] skip;
		logic [7:0] run_len;
		logic [7:0] close_len;
		logic [7:0] rem;
	} cmd_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic nonempty;
	} queue_stat_t;

endpackage

`default_nettype wire

// ===== hdl/vcse_front.sv =====
// ----------------------------------------------------------------------------
// vcse_front
// Accepts voxel requests, checks them against the column state, updates the
// state and pushes one command word per request into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vcse_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  voxel_valid,
	output logic                       voxel_stall,
	input  wire vcse_pkg::voxel_t      voxel_data,
	input  wire logic [7:0]            column_height,
	input  wire vcse_pkg::queue_stat_t qstat,
	output logic                       push,
	output vcse_pkg::cmd_t             push_cmd
);

	vcse_pkg::offset_t bp_q;
	vcse_pkg::offset_t rs_q;
	vcse_pkg::offset_t cs_q;
	logic [7:0]        rl_q;
	logic [8:0]        nfz_q;
	logic              open_q;
	logic              inside_q;
	logic              err_q;

	vcse_pkg::offset_t  eff_bp;
	vcse_pkg::offset_t  eff_cs;
	logic [8:0]         eff_nfz;
	logic               eff_open;
	logic [7:0]         eff_rl;
	logic               bad;
	logic               extend;
	logic [7:0]         new_rl;
	vcse_pkg::offset_t  run_bp;
	vcse_pkg::offset_t  body_end;
	vcse_pkg::offset_t  bp_next;
	logic [8:0]         z1;
	vcse_pkg::slot_mask_t mask;
	logic               accept;

	assign voxel_stall = qstat.full;
	assign accept      = voxel_valid && !qstat.full;
	assign push        = accept;

	// column open view of the state
	always_comb begin
		eff_bp   = (!inside_q && voxel_data.section_first) ? '0 : bp_q;
		eff_cs   = inside_q ? cs_q : eff_bp;
		eff_nfz  = inside_q ? nfz_q : 9'd0;
		eff_open = inside_q && open_q;
		eff_rl   = inside_q ? rl_q : 8'd0;
	end

	// classify the request
	always_comb begin
		bad      = (voxel_data.voxel_z >= column_height) ||
		           ({1'b0, voxel_data.voxel_z} < eff_nfz);
		extend   = eff_open && ({1'b0, voxel_data.voxel_z} == eff_nfz);
		new_rl   = extend ? eff_rl + 8'd1 : 8'd1;
		run_bp   = (eff_open && !extend) ? eff_bp + vcse_pkg::offset_t'(1) : eff_bp;
		body_end = extend ? eff_bp + vcse_pkg::offset_t'(2)
		                  : run_bp + vcse_pkg::offset_t'(4);
		bp_next  = voxel_data.column_last ? body_end + vcse_pkg::offset_t'(3) : body_end;
		z1       = {1'b0, voxel_data.voxel_z} + 9'd1;

		mask = '0;
		if (err_q || bad) begin
			mask[vcse_pkg::SLOT_ERR] = 1'b1;
		end else begin
			mask[vcse_pkg::SLOT_COL] = 1'b1;
			mask[vcse_pkg::SLOT_NRM] = 1'b1;
			if (extend) begin
				mask[vcse_pkg::SLOT_PATCH] = 1'b1;
			end else begin
				mask[vcse_pkg::SLOT_CLOSE] = eff_open;
				mask[vcse_pkg::SLOT_SKIP]  = 1'b1;
				mask[vcse_pkg::SLOT_ONE]   = 1'b1;
			end
			if (voxel_data.column_last) begin
				mask[vcse_pkg::SLOT_TRAIL] = 1'b1;
				mask[vcse_pkg::SLOT_REM]   = 1'b1;
				mask[vcse_pkg::SLOT_ZERO]  = 1'b1;
			end
		end
	end

	// command word
	always_comb begin
		push_cmd.mask      = mask;
		push_cmd.base      = eff_bp;
		push_cmd.patch_off = rs_q + vcse_pkg::offset_t'(1);
		push_cmd.col_start = err_q ? cs_q : eff_cs;
		push_cmd.color     = voxel_data.color_index;
		push_cmd.normal    = voxel_data.normal_index;
		push_cmd.skip      = voxel_data.voxel_z - eff_nfz[7:0];
		push_cmd.run_len   = new_rl;
		push_cmd.close_len = eff_rl;
		push_cmd.rem       = column_height - z1[7:0];
	end

	// column state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q     <= '0;
			rs_q     <= '0;
			cs_q     <= '0;
			rl_q     <= '0;
			nfz_q    <= '0;
			open_q   <= 1'b0;
			inside_q <= 1'b0;
			err_q    <= 1'b0;
		end else if (accept && !err_q) begin
			if (bad) begin
				bp_q   <= eff_bp;
				cs_q   <= eff_cs;
				nfz_q  <= eff_nfz;
				open_q <= eff_open;
				rl_q   <= eff_rl;
				err_q  <= 1'b1;
			end else begin
				bp_q     <= bp_next;
				cs_q     <= eff_cs;
				rs_q     <= extend ? rs_q : run_bp;
				rl_q     <= new_rl;
				nfz_q    <= z1;
				open_q   <= !voxel_data.column_last;
				inside_q <= !voxel_data.column_last;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/vcse_queue.sv =====
// ----------------------------------------------------------------------------
// vcse_queue
// Small command FIFO that decouples the front from the write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module vcse_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire vcse_pkg::cmd_t        push_cmd,
	input  wire logic                  pop,
	output vcse_pkg::queue_stat_t      qstat,
	output vcse_pkg::cmd_t             head
);

	vcse_pkg::cmd_t                 entry_q [vcse_pkg::QUEUE_DEPTH];
	logic [vcse_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [vcse_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [vcse_pkg::QCNT_BITS-1:0] count_q;
	logic                           do_push;
	logic                           do_pop;

	localparam logic [vcse_pkg::QPTR_BITS-1:0] LAST_PTR =
		vcse_pkg::QPTR_BITS'(vcse_pkg::QUEUE_DEPTH - 1);

	assign qstat.full     = (count_q == vcse_pkg::QCNT_BITS'(vcse_pkg::QUEUE_DEPTH));
	assign qstat.nonempty = (count_q != '0);
	assign do_push        = push && !qstat.full;
	assign do_pop         = pop && qstat.nonempty;
	assign head           = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/vcse_back.sv =====
// ----------------------------------------------------------------------------
// vcse_back
// Write sequencer: walks the slot mask of the queue head and emits one
// address-tagged byte write per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module vcse_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire vcse_pkg::queue_stat_t qstat,
	input  wire vcse_pkg::cmd_t        head,
	output logic                       pop,
	output logic                       write_valid,
	input  wire logic                  write_stall,
	output vcse_pkg::write_t           write_data
);

	logic                 active_q;
	vcse_pkg::slot_mask_t mask_q;
	vcse_pkg::offset_t    off_q;
	logic                 out_valid_q;
	vcse_pkg::write_t     out_q;

	vcse_pkg::slot_mask_t cur_mask;
	vcse_pkg::offset_t    cur_off;
	vcse_pkg::slot_t      slot;
	vcse_pkg::slot_mask_t remaining;
	logic                 can_load;
	logic                 fire;
	logic                 done;
	logic                 step_off;
	vcse_pkg::write_t     wr;

	assign write_valid = out_valid_q;
	assign write_data  = out_q;

	// current slot of the head command
	always_comb begin
		cur_mask = active_q ? mask_q : head.mask;
		cur_off  = active_q ? off_q : head.base;
		slot     = vcse_pkg::SLOT_ERR;
		for (int i = vcse_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (cur_mask[i]) begin
				slot = vcse_pkg::slot_t'(4'(i));
			end
		end
		remaining = cur_mask & ~(vcse_pkg::slot_mask_t'(1) << slot);
		done      = (remaining == '0);
		can_load  = !out_valid_q || !write_stall;
		fire      = qstat.nonempty && can_load;
		pop       = fire && done;
		step_off  = (slot != vcse_pkg::SLOT_PATCH) && (slot != vcse_pkg::SLOT_ERR);
	end

	// byte write for the slot
	always_comb begin
		wr.write_offset = 24'(cur_off);
		wr.write_byte   = 8'd0;
		wr.column_start = 24'(head.col_start);
		wr.column_done  = 1'b0;
		wr.encode_error = 1'b0;
		wr.last_write   = done;
		unique case (slot)
			vcse_pkg::SLOT_CLOSE: wr.write_byte = head.close_len;
			vcse_pkg::SLOT_SKIP:  wr.write_byte = head.skip;
			vcse_pkg::SLOT_ONE:   wr.write_byte = 8'd1;
			vcse_pkg::SLOT_COL:   wr.write_byte = head.color;
			vcse_pkg::SLOT_NRM:   wr.write_byte = head.normal;
			vcse_pkg::SLOT_PATCH: begin
				wr.write_offset = 24'(head.patch_off);
				wr.write_byte   = head.run_len;
			end
			vcse_pkg::SLOT_TRAIL: wr.write_byte = head.run_len;
			vcse_pkg::SLOT_REM:   wr.write_byte = head.rem;
			vcse_pkg::SLOT_ZERO:  wr.column_done = 1'b1;
			vcse_pkg::SLOT_ERR: begin
				wr.write_offset = '0;
				wr.encode_error = 1'b1;
			end
			default: wr.write_byte = 8'd0;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= wr;
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			mask_q      <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_load) begin
				out_valid_q <= fire;
			end
			if (fire) begin
				active_q <= !done;
				mask_q   <= remaining;
				off_q    <= step_off ? cur_off + vcse_pkg::offset_t'(1) : cur_off;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/voxel_column_span_encoder.sv =====
// ----------------------------------------------------------------------------
// voxel_column_span_encoder
// Turns the ascending voxels of a column into span data byte writes.
// ----------------------------------------------------------------------------
// The front accepts one voxel request per cycle while the two-entry command
// queue has room; the back emits one byte write per cycle unless stalled.
// A voxel causes 3 byte writes when it extends a run, 4 or 5 when it opens
// one, 3 more when it closes the column, 1 on error. Throughput is set by the
// single write port of the output register. The user must write column_height
// through the APB port at address 0 only while the block is idle; the block
// does not enforce this. There is no clearing pass after reset.
`default_nettype none

module voxel_column_span_encoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          voxel_valid,
	output logic                               voxel_stall,
	input  wire vcse_pkg::voxel_t              voxel_data,
	output logic                               write_valid,
	input  wire logic                          write_stall,
	output vcse_pkg::write_t                   write_data,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [vcse_pkg::PADDR_BITS-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	logic [7:0]            height_q;
	logic                  push;
	logic                  pop;
	vcse_pkg::cmd_t        push_cmd;
	vcse_pkg::cmd_t        head;
	vcse_pkg::queue_stat_t qstat;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == vcse_pkg::ADDR_COLUMN_HEIGHT) ? {24'd0, height_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= vcse_pkg::COLUMN_HEIGHT_RESET;
		end else if (psel && penable && pwrite && paddr == vcse_pkg::ADDR_COLUMN_HEIGHT) begin
			height_q <= pwdata[7:0];
		end
	end

	vcse_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.voxel_valid   (voxel_valid),
		.voxel_stall   (voxel_stall),
		.voxel_data    (voxel_data),
		.column_height (height_q),
		.qstat         (qstat),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	vcse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.qstat    (qstat),
		.head     (head)
	);

	vcse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.head        (head),
		.pop         (pop),
		.write_valid (write_valid),
		.write_stall (write_stall),
		.write_data  (write_data)
	);

endmodule

`default_nettype wire

// ===== hdl/vcse_checker.sv =====
// ----------------------------------------------------------------------------
// vcse_checker
// Port-level checks of the span encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vcse_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          write_valid,
	input wire logic                          write_stall,
	input wire vcse_pkg::write_t              write_data
);

	logic err_seen_q;

	// an error write has been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (write_valid && !write_stall && write_data.encode_error) begin
			err_seen_q <= 1'b1;
		end
	end

	// stalled write holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		write_valid && write_stall |=> write_valid && $stable(write_data))
		else $error("stalled write changed");

	// error stays sticky on the write side
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		write_valid && err_seen_q |-> write_data.encode_error)
		else $error("error flag dropped");

	// error write is a lone zero write
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		write_valid && write_data.encode_error |->
			write_data.last_write && write_data.write_offset == 24'd0 &&
			write_data.write_byte == 8'd0 && !write_data.column_done)
		else $error("malformed error write");

	// column end is the zero byte that ends the request
	a_done_form: assert property (@(posedge clk) disable iff (!arst_n)
		write_valid && write_data.column_done |->
			write_data.last_write && write_data.write_byte == 8'd0)
		else $error("malformed column end");

endmodule

bind voxel_column_span_encoder vcse_checker u_vcse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.write_valid (write_valid),
	.write_stall (write_stall),
	.write_data  (write_data)
);

`default_nettype wire
